@@ rtl/epoch_seconds_to_civil_time_core_macros.svh @@
// assertion macros for the epoch seconds to civil time core
`ifndef EPOCH_SECONDS_TO_CIVIL_TIME_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_TIME_CORE_MACROS_SVH

// checked only while out of reset
`define ESCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define ESCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/esct_pkg.sv @@
// shared constants for the epoch seconds to civil time core
package esct_pkg;

  localparam int NumStages = 12;
  localparam int InW       = 39;
  localparam int YearW     = 15;

  // seconds to days: shift by 7, then divide by 675 with a reciprocal
  localparam longint DayDiv      = 675;
  localparam int     DayBiasBits = 22;
  localparam logic [32:0] DayBias  = 33'(DayDiv * (64'd1 << DayBiasBits));
  localparam logic [24:0] DayRecip = 25'((64'd1 << 34) / DayDiv);
  localparam logic [16:0] SecsPerDay = 17'd86400;

  // day count rebased to march 1 of year 0, padded by whole eras
  localparam longint ShiftToMarch = 719468;
  localparam longint EraDays      = 146097;
  localparam longint EraPad       = 32;
  localparam logic [23:0] VBias =
    24'(ShiftToMarch + EraDays * EraPad - (64'd1 << DayBiasBits));
  localparam logic [24:0] EraRecip = 25'(((64'd1 << 42) + EraDays - 1) / EraDays);
  localparam logic [14:0] EraYearBias = 15'(EraPad * 400);

  localparam logic [17:0] DaysInCentury = 18'd36524;

  // exact reciprocals for small ranges
  localparam logic [17:0] MinRecip  = 18'(((64'd1 << 23) + 59) / 60);
  localparam logic [11:0] HourRecip = 12'(((64'd1 << 17) + 59) / 60);
  localparam logic [17:0] YearRecip = 18'(((64'd1 << 26) + 364) / 365);
  localparam logic [11:0] MonRecip  = 12'(((64'd1 << 19) + 152) / 153);

  localparam logic [8:0] MarchToDec = 9'd306;

endpackage

@@ rtl/esct_if.sv @@
// input and result channels of the epoch seconds to civil time core
interface esct_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [esct_pkg::InW-1:0]   unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink (input valid, input unix_seconds, output ready);
endinterface

interface esct_out_if;
  logic                                valid;
  logic                                ready;
  logic [5:0]                          second;
  logic [5:0]                          minute;
  logic [4:0]                          hour;
  logic [2:0]                          weekday;
  logic [8:0]                          day_of_year;
  logic signed [esct_pkg::YearW-1:0]   year;
  logic [3:0]                          month;
  logic [4:0]                          day_of_month;

  modport source (
    output valid, output second, output minute, output hour, output weekday,
    output day_of_year, output year, output month, output day_of_month,
    input ready
  );
  modport sink (
    input valid, input second, input minute, input hour, input weekday,
    input day_of_year, input year, input month, input day_of_month,
    output ready
  );
endinterface

@@ rtl/esct_date.sv @@
// date path: day count to weekday, year, month, day of month and day of year
module esct_date (
  input  logic                                clk_i,
  input  logic [esct_pkg::NumStages-1:0]      en_i,
  input  logic [23:0]                         days_i,
  output logic [2:0]                          weekday_o,
  output logic [8:0]                          day_of_year_o,
  output logic signed [esct_pkg::YearW-1:0]   year_o,
  output logic [3:0]                          month_o,
  output logic [4:0]                          day_of_month_o
);

  typedef struct packed {
    logic [2:0]  wd;
    logic [14:0] base;
  } carry_t;

  function automatic logic [2:0] mod7(input logic [24:0] x);
    logic [26:0] xp;
    logic [5:0]  s;
    logic [3:0]  t;
    xp = {2'b00, x};
    s  = '0;
    for (int i = 0; i < 9; i++) begin
      s = s + 6'(xp[3*i +: 3]);
    end
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd14) begin
      mod7 = 3'(t - 4'd14);
    end else if (t >= 4'd7) begin
      mod7 = 3'(t - 4'd7);
    end else begin
      mod7 = t[2:0];
    end
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    month_start = r;
  endfunction

  logic [23:0] v_q, v4_q;
  logic [6:0]  era_q;
  logic [17:0] eday5_q, eday6_q, eday7_q, eday8_q;
  logic [6:0]  a6_q;
  logic [2:0]  b6_q;
  logic        c6_q;
  logic [17:0] n7_q;
  logic [8:0]  eyear8_q, eyear9_q, eyear10_q;
  logic [8:0]  ydm9_q, ydm10_q;
  logic        leap9_q, leap10_q;
  logic [3:0]  monm10_q;
  carry_t      carry_q [5:10];

  logic [48:0] era_prod;
  logic [35:0] a_prod, ey_prod;
  logic [10:0] mx;
  logic [22:0] mm_prod;
  logic [1:0]  cent;
  logic [8:0]  ydm_d, start, dom;

  assign era_prod = 49'(v_q) * 49'(esct_pkg::EraRecip);
  assign a_prod   = 36'(eday5_q) * 36'(esct_pkg::YearRecip);
  assign ey_prod  = 36'(n7_q) * 36'(esct_pkg::YearRecip);
  assign cent     = 2'(eyear8_q >= 9'd100) + 2'(eyear8_q >= 9'd200) + 2'(eyear8_q >= 9'd300);
  assign ydm_d    = eday8_q[8:0]
                    - (eyear8_q * 9'd365 + {2'b00, eyear8_q[8:2]} - {7'd0, cent});
  assign mx       = {2'b00, ydm9_q} * 11'd5 + 11'd2;
  assign mm_prod  = 23'(mx) * 23'(esct_pkg::MonRecip);
  assign start    = month_start(monm10_q);
  assign dom      = ydm10_q - start + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      v_q <= days_i + esct_pkg::VBias;
    end
    if (en_i[4]) begin
      era_q <= era_prod[48:42];
      v4_q  <= v_q;
    end
    if (en_i[5]) begin
      eday5_q          <= v4_q[17:0] - 18'(era_q * 18'(esct_pkg::EraDays));
      carry_q[5].wd    <= mod7(25'(v4_q) + 25'd3);
      carry_q[5].base  <= 15'(era_q * 15'd400) - esct_pkg::EraYearBias;
    end
    for (int k = 6; k <= 10; k++) begin
      if (en_i[k]) begin
        carry_q[k] <= carry_q[k-1];
      end
    end
    if (en_i[6]) begin
      a6_q    <= a_prod[34:28];
      b6_q    <= 3'(eday5_q >= esct_pkg::DaysInCentury)
               + 3'(eday5_q >= 18'(2 * esct_pkg::DaysInCentury))
               + 3'(eday5_q >= 18'(3 * esct_pkg::DaysInCentury))
               + 3'(eday5_q >= 18'(4 * esct_pkg::DaysInCentury));
      c6_q    <= (eday5_q == 18'(esct_pkg::EraDays - 1));
      eday6_q <= eday5_q;
    end
    if (en_i[7]) begin
      n7_q    <= eday6_q - 18'(a6_q) + 18'(b6_q) - 18'(c6_q);
      eday7_q <= eday6_q;
    end
    if (en_i[8]) begin
      eyear8_q <= ey_prod[34:26];
      eday8_q  <= eday7_q;
    end
    if (en_i[9]) begin
      ydm9_q   <= ydm_d;
      leap9_q  <= (eyear8_q[1:0] == 2'b00)
                  && !(eyear8_q == 9'd100 || eyear8_q == 9'd200 || eyear8_q == 9'd300);
      eyear9_q <= eyear8_q;
    end
    if (en_i[10]) begin
      monm10_q  <= mm_prod[22:19];
      ydm10_q   <= ydm9_q;
      leap10_q  <= leap9_q;
      eyear10_q <= eyear9_q;
    end
    if (en_i[11]) begin
      weekday_o      <= carry_q[10].wd;
      day_of_month_o <= dom[4:0];
      month_o        <= (monm10_q < 4'd10) ? monm10_q + 4'd2 : monm10_q - 4'd10;
      year_o         <= carry_q[10].base + 15'(eyear10_q) + 15'(monm10_q >= 4'd10);
      day_of_year_o  <= (ydm10_q >= esct_pkg::MarchToDec)
                        ? ydm10_q - esct_pkg::MarchToDec
                        : ydm10_q + 9'd59 + {8'd0, leap10_q};
    end
  end

endmodule

@@ rtl/epoch_seconds_to_civil_time_core.sv @@
// top level of the epoch seconds to civil time core
//
// converts a signed 39-bit count of seconds since 1970-01-01 00:00:00 utc
// into broken-down utc time (second, minute, hour, weekday, day of year,
// year, month from 0, day of month), proleptic gregorian calendar
//
// channels: src_i takes one timestamp per transfer, res_o gives one result
// per timestamp, in order; both are valid/ready, a transfer happens on a
// rising edge with valid and ready high
//
// timing: 12 register stages, one timestamp per clock sustained while res_o
// takes results or a stage is empty. the depth comes from the
// multiply-by-reciprocal divisions (seconds to days, days to eras, era
// days to year, year days to month), each followed by a register
//
// stalls: every stage has its own valid bit and loads when it is empty or
// when some later stage frees up, so bubbles collapse and src_i.ready stays
// high while the pipe still has a hole; with res_o stalled and all stages
// full, src_i.ready drops and nothing is lost or repeated
//
// reset: rst_ni clears all valid bits asynchronously; no other state
`include "epoch_seconds_to_civil_time_core_macros.svh"

module epoch_seconds_to_civil_time_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  esct_in_if.sink       src_i,
  esct_out_if.source    res_o
);

  localparam int Ns = esct_pkg::NumStages;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
  } tod_t;

  // pipeline control
  logic [Ns-1:0] vld_q, vld_d, en;

  always_comb begin
    for (int k = 0; k < Ns; k++) begin
      // a stage may load when the receiver takes or any stage from here on is empty
      en[k] = res_o.ready || !(&(vld_q | Ns'((1 << k) - 1)));
    end
  end

  assign vld_d       = {vld_q[Ns-2:0], src_i.valid};
  assign src_i.ready = en[0];
  assign res_o.valid = vld_q[Ns-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Ns; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // seconds split into days and second of day
  logic [32:0] u_d, u_q;
  logic [6:0]  r1_q, r1b_q;
  logic [57:0] day_prod;
  logic [23:0] qe_q, days_q, days_d;
  logic [10:0] ulo_q, rem_raw, rem;
  logic        fix;
  logic [16:0] sod_q, sod3_q, sod_d;

  // arithmetic shift by 7 is floor division by 128; the bias keeps u positive
  assign u_d = {src_i.unix_seconds[esct_pkg::InW-1], src_i.unix_seconds[esct_pkg::InW-1:7]}
               + esct_pkg::DayBias;

  // reciprocal estimate is exact or one low
  assign day_prod = 58'(u_q) * 58'(esct_pkg::DayRecip);
  assign rem_raw  = ulo_q - 11'(qe_q[10:0] * 11'(esct_pkg::DayDiv));
  assign fix      = rem_raw >= 11'(esct_pkg::DayDiv);
  assign days_d   = fix ? qe_q + 24'd1 : qe_q;
  assign rem      = fix ? rem_raw - 11'(esct_pkg::DayDiv) : rem_raw;
  assign sod_d    = {rem[9:0], r1b_q};

  // time of day
  logic [34:0] mt_prod;
  logic [22:0] hr_prod;
  logic [10:0] mt3_q;
  logic [5:0]  mt4_q, sec4_q;
  logic [4:0]  hour4_q;
  tod_t        tod_q [5:Ns-1];

  assign mt_prod = 35'(sod_q) * 35'(esct_pkg::MinRecip);
  assign hr_prod = 23'(mt3_q) * 23'(esct_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q  <= u_d;
      r1_q <= src_i.unix_seconds[6:0];
    end
    if (en[1]) begin
      qe_q  <= day_prod[57:34];
      ulo_q <= u_q[10:0];
      r1b_q <= r1_q;
    end
    if (en[2]) begin
      days_q <= days_d;
      sod_q  <= sod_d;
    end
    if (en[3]) begin
      mt3_q  <= mt_prod[33:23];
      sod3_q <= sod_q;
    end
    if (en[4]) begin
      sec4_q  <= sod3_q[5:0] - 6'(mt3_q[5:0] * 6'd60);
      hour4_q <= hr_prod[21:17];
      mt4_q   <= mt3_q[5:0];
    end
    if (en[5]) begin
      tod_q[5].sec  <= sec4_q;
      tod_q[5].min  <= mt4_q - 6'(hour4_q * 6'd60);
      tod_q[5].hour <= hour4_q;
    end
    for (int k = 6; k < Ns; k++) begin
      if (en[k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  // calendar date from the day count
  esct_date u_date (
    .clk_i          (clk_i),
    .en_i           (en),
    .days_i         (days_q),
    .weekday_o      (res_o.weekday),
    .day_of_year_o  (res_o.day_of_year),
    .year_o         (res_o.year),
    .month_o        (res_o.month),
    .day_of_month_o (res_o.day_of_month)
  );

  assign res_o.second = tod_q[Ns-1].sec;
  assign res_o.minute = tod_q[Ns-1].min;
  assign res_o.hour   = tod_q[Ns-1].hour;

  `ESCT_ASSERT_ALWAYS(a_ready_when_taken, res_o.ready |-> src_i.ready, "input blocked while output drains")
  `ESCT_ASSERT(a_sod_range, vld_q[2] |-> (sod_q < esct_pkg::SecsPerDay), "second of day out of range")
  `ESCT_ASSERT(a_tod_range, res_o.valid |-> (res_o.second < 6'd60 && res_o.minute < 6'd60 && res_o.hour < 5'd24), "time of day out of range")
  `ESCT_ASSERT(a_date_range, res_o.valid |-> (res_o.weekday < 3'd7 && res_o.month < 4'd12 && res_o.day_of_month != 5'd0 && res_o.day_of_year < 9'd366), "date field out of range")

endmodule

@@ tb/epoch_seconds_to_civil_time_core_tb.sv @@
// testbench for the epoch seconds to civil time core: directed table, random stamps, scoreboard
module epoch_seconds_to_civil_time_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [esct_pkg::InW-1:0] stamp_t;

  // one broken-down utc result, field for field as on res_o
  typedef struct packed {
    logic [5:0]                        second;
    logic [5:0]                        minute;
    logic [4:0]                        hour;
    logic [2:0]                        weekday;
    logic [8:0]                        day_of_year;
    logic signed [esct_pkg::YearW-1:0] year;
    logic [3:0]                        month;
    logic [4:0]                        day_of_month;
  } civil_t;

  // one row of the directed table; a typed row carries its own answer
  typedef struct {
    stamp_t stamp;
    bit     typed;
    civil_t want;
  } stim_row_t;

  localparam longint SecsPerDayL   = 86400;
  localparam longint MarchShift    = 719468;
  localparam longint DaysPerEra    = 146097;
  localparam longint DaysPerCent   = 36524;
  localparam longint DaysPer4Yr    = 1461;
  localparam longint MarToDecDays  = 306;
  localparam longint StampLow      = -64'sd62170070400;
  localparam longint StampHigh     = 64'sd253402387199;
  localparam int     RandomStamps  = 700;
  localparam int     HoldAfter     = 300;   // sink holds off once this many have gone in
  localparam int     HoldCycles    = 150;
  localparam int     PauseAt       = 450;   // source drains the pipe after this random stamp
  localparam int     DrainCycles   = 36;    // idle tail after the final drain
  localparam real    TimeoutNs     = 10_000_000.0;

  logic clk_i;
  logic rst_ni;

  esct_in_if  src_if ();
  esct_out_if res_if ();

  epoch_seconds_to_civil_time_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if),
    .res_o  (res_if)
  );

  civil_t    civil_due [$];   // predicted results, oldest first
  stim_row_t dir_rows  [$];
  int        stamps_sent;
  int        results_seen;
  int        fail_count;
  bit        hold_done;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // predictor: floor split into days and second of day, then
  // civil-from-days on eras counted from march 1 of year 0
  function automatic civil_t civil_from_stamp(input stamp_t stamp);
    longint secs, days, sod, era, eday, eyear, yday_m, mon_m, dom, mon, yr, yday, wd;
    bit     leap;
    civil_t c;
    secs = stamp;
    days = secs / SecsPerDayL;
    if ((secs % SecsPerDayL) != 0 && secs < 0) days--;
    sod  = secs - days * SecsPerDayL;
    days = days + MarchShift;
    era  = days / DaysPerEra;
    if ((days % DaysPerEra) != 0 && days < 0) era--;
    eday   = days - era * DaysPerEra;
    eyear  = (eday - eday / (DaysPer4Yr - 1) + eday / DaysPerCent
              - eday / (DaysPerEra - 1)) / 365;
    yday_m = eday - (365 * eyear + eyear / 4 - eyear / 100);
    mon_m  = (5 * yday_m + 2) / 153;
    dom    = yday_m - (153 * mon_m + 2) / 5 + 1;
    mon    = (mon_m < 10) ? mon_m + 2 : mon_m - 10;
    yr     = eyear + era * 400 + ((mon <= 1) ? 1 : 0);
    // leap test on the march-based year inside its era
    leap   = (eyear % 4 == 0) && ((eyear % 100 != 0) || eyear == 0);
    yday   = (yday_m >= MarToDecDays) ? yday_m - MarToDecDays : yday_m + 59 + (leap ? 1 : 0);
    wd     = (days + 3) % 7;
    if (wd < 0) wd += 7;
    c.second       = 6'(sod % 60);
    c.minute       = 6'((sod / 60) % 60);
    c.hour         = 5'(sod / 3600);
    c.weekday      = 3'(wd);
    c.day_of_year  = 9'(yday);
    c.year         = yr[esct_pkg::YearW-1:0];
    c.month        = 4'(mon);
    c.day_of_month = 5'(dom);
    return c;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_row(input stamp_t stamp, input bit typed, input civil_t want);
    stim_row_t r;
    r.stamp = stamp;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // offer one stamp after an optional gap and wait for its transfer;
  // valid stays high afterwards so back-to-back stamps need no extra edge
  task automatic send_stamp(input stamp_t stamp, input int unsigned gap,
                            input bit typed, input civil_t typed_want);
    if (gap != 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid        <= 1'b1;
    src_if.unix_seconds <= stamp;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    civil_due.push_back(typed ? typed_want : civil_from_stamp(stamp));
    stamps_sent++;
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic drain_results();
    src_if.valid <= 1'b0;
    do @(posedge clk_i); while (civil_due.size() != 0);
  endtask

  // result sink: stretches of steady ready, random ready, short stalls,
  // and one long hold-off so the pipe fills and src_i.ready drops
  initial begin : result_sink
    int unsigned pick;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_done && stamps_sent >= HoldAfter) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          res_if.ready <= 1'b1;
          repeat ($urandom_range(5, 40)) @(posedge clk_i);
        end else if (pick < 9) begin
          res_if.ready <= 1'($urandom_range(0, 1));
          @(posedge clk_i);
        end else begin
          res_if.ready <= 1'b0;
          repeat ($urandom_range(8, 30)) @(posedge clk_i);
        end
      end
    end
  end

  // scoreboard: every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    civil_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (civil_due.size() == 0) begin
        $error("result transfer with nothing expected (year %0d)", res_if.year);
        fail_count++;
      end else begin
        want = civil_due.pop_front();
        if (res_if.second !== want.second) begin
          $error("second: expected %0d, got %0d", want.second, res_if.second);
          fail_count++;
        end
        if (res_if.minute !== want.minute) begin
          $error("minute: expected %0d, got %0d", want.minute, res_if.minute);
          fail_count++;
        end
        if (res_if.hour !== want.hour) begin
          $error("hour: expected %0d, got %0d", want.hour, res_if.hour);
          fail_count++;
        end
        if (res_if.weekday !== want.weekday) begin
          $error("weekday: expected %0d, got %0d", want.weekday, res_if.weekday);
          fail_count++;
        end
        if (res_if.day_of_year !== want.day_of_year) begin
          $error("day_of_year: expected %0d, got %0d", want.day_of_year, res_if.day_of_year);
          fail_count++;
        end
        if (res_if.year !== want.year) begin
          $error("year: expected %0d, got %0d", want.year, res_if.year);
          fail_count++;
        end
        if (res_if.month !== want.month) begin
          $error("month: expected %0d, got %0d", want.month, res_if.month);
          fail_count++;
        end
        if (res_if.day_of_month !== want.day_of_month) begin
          $error("day_of_month: expected %0d, got %0d", want.day_of_month, res_if.day_of_month);
          fail_count++;
        end
      end
    end
  end

  initial begin : main_seq
    longint unsigned span, day_span, r;
    longint          v;
    stamp_t          s;
    int unsigned     pick;
    civil_t          none;
    none         = '0;
    stamps_sent  = 0;
    results_seen = 0;
    fail_count   = 0;
    hold_done    = 1'b0;
    rst_ni              <= 1'b0;
    src_if.valid        <= 1'b0;
    src_if.unix_seconds <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: the epoch, one second before it, both range ends typed in
    add_row(39'sd0, 1'b1, civil_t'{6'd0, 6'd0, 5'd0, 3'd4, 9'd0, 15'sd1970, 4'd0, 5'd1});
    add_row(-39'sd1, 1'b1, civil_t'{6'd59, 6'd59, 5'd23, 3'd3, 9'd364, 15'sd1969, 4'd11, 5'd31});
    add_row(-39'sd62170070400, 1'b1,
            civil_t'{6'd0, 6'd0, 5'd0, 3'd1, 9'd332, -15'sd1, 4'd10, 5'd29});
    add_row(39'sd253402387199, 1'b1,
            civil_t'{6'd59, 6'd59, 5'd23, 3'd6, 9'd0, 15'sd10000, 4'd0, 5'd1});
    // day boundaries around the epoch, negative side rounds toward minus infinity
    add_row(39'sd1, 1'b0, none);
    add_row(39'sd86399, 1'b0, none);
    add_row(39'sd86400, 1'b0, none);
    add_row(-39'sd86400, 1'b0, none);
    add_row(-39'sd86401, 1'b0, none);
    // leap days, era starts and the century years the leap rule singles out
    add_row(39'sd951782400, 1'b0, none);      // 2000-02-29
    add_row(39'sd951868800, 1'b0, none);      // 2000-03-01, start of an era
    add_row(39'sd978220800, 1'b0, none);      // 2000-12-31, day 365
    add_row(39'sd4107456000, 1'b0, none);     // 2100-02-28
    add_row(39'sd4107542400, 1'b0, none);     // 2100-03-01, no leap day before it
    add_row(-39'sd2203891200, 1'b0, none);    // 1900-03-01
    add_row(39'sd13574649600, 1'b0, none);    // 2400-03-01
    add_row(-39'sd11670912000, 1'b0, none);   // 1600-03-01
    add_row(39'sd1709251199, 1'b0, none);     // end of 2024-02-29
    // year 0 and its neighbors
    add_row(-39'sd62167219201, 1'b0, none);   // last second of year -1
    add_row(-39'sd62162121600, 1'b0, none);   // 0000-02-29
    add_row(-39'sd62162035200, 1'b0, none);   // 0000-03-01
    add_row(-39'sd62135596800, 1'b0, none);   // 0001-01-01
    add_row(39'sd253402300799, 1'b0, none);   // end of 9999
    // full 39-bit extremes, outside the stated range
    add_row(39'sd274877906943, 1'b0, none);
    add_row(-39'sd274877906944, 1'b0, none);

    foreach (dir_rows[i])
      send_stamp(dir_rows[i].stamp, idle_gap(), dir_rows[i].typed, dir_rows[i].want);

    // random part: mostly in range, some on day edges, some raw 39-bit noise
    span     = longint'(StampHigh - StampLow + 1);
    day_span = span / SecsPerDayL;
    for (int n = 0; n < RandomStamps; n++) begin
      pick = $urandom_range(0, 9);
      r    = {$urandom, $urandom};
      if (pick < 6) begin
        v = StampLow + longint'(r % span);
        s = stamp_t'(v);
      end else if (pick < 9) begin
        v = StampLow + longint'(r % day_span) * SecsPerDayL;
        case ($urandom_range(0, 2))
          0: v = v;
          1: v = v + SecsPerDayL - 1;
          default: v = v + $urandom_range(0, 86399);
        endcase
        s = stamp_t'(v);
      end else begin
        s = stamp_t'(r[esct_pkg::InW-1:0]);
      end
      send_stamp(s, idle_gap(), 1'b0, none);
      if (n == PauseAt) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d timestamps: %0d from the table, %0d random, %0d results checked",
             stamps_sent, dir_rows.size(), RandomStamps, results_seen);
    $display("included a %0d-cycle result hold-off and a full drain pause mid-run", HoldCycles);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog against a stuck handshake
  initial begin : watchdog
    #(TimeoutNs);
    $display("timeout with %0d results still expected", civil_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
